// File: hw/rtl/rbd_pkg.sv
// Shared types and constants for the RGBA box downsampler.
// No dependencies; used by rgba_box_downsample.
`default_nettype none
package rbd_pkg;

    localparam int SRC_MAX_DEF = 4096;
    localparam int DST_MAX_DEF = 256;
    localparam int PIX_W       = 8;
    localparam int NUM_CH      = 4;
    localparam int CFG_W       = 13;
    localparam int SRC_CFG_W   = 13;
    localparam int DST_CFG_W   = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int POS_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

    typedef struct packed {
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
        logic [PIX_W-1:0] in_alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_alpha;
        logic [POS_W-1:0] out_col;
        logic [POS_W-1:0] out_row;
        logic             frame_last;
    } pixel_out_t;

    typedef enum logic [2:0] {
        ST_SETUP_GO,
        ST_SETUP_WAIT,
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/rbd_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; instantiated by rgba_box_downsample.
`default_nettype none
module rbd_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 26,
    parameter int Q_W   = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [Q_W-1:0]        quot,
    output logic [DEN_W-1:0]      rem
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // Numerator bits above the quotient field seed the partial remainder;
    // the caller keeps them below the divisor.
    always_comb
    begin
        trial     = {rem_reg, quot_reg[Q_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quot_next = (quot_reg << 1) | Q_W'(ge);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= DEN_W'(num >> Q_W);
            quot_reg <= num[Q_W-1:0];
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// File: hw/rtl/rgba_box_downsample.sv
// Streaming box-filter downsampler for RGBA8, top level.
// Depends on rbd_pkg and rbd_div.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------
//  src      | src_valid / src_ready   | src_pixel  (pixel_in_t)
//  dst      | dst_valid / dst_ready   | dst_pixel  (pixel_out_t)
//  cfg      | cfg_we (no back-press.) | cfg_index, cfg_data
//
// A pixel that closes no window goes through a column-store read, then
// read-modify-write of that column's sums.
// A pixel that closes a window goes through the read, the update with the
// window-size multiply, the divider load, 8 divider steps and the done flag,
// and the output load.
// After reset and after every register write, the SETUP_GO and SETUP_WAIT
// states derive the window step sizes; no pixel is taken then.
// The output register holds a result while dst_ready is low; the next
// pixel is still taken, and a second result waits in the divider.
`default_nettype none
module rgba_box_downsample #(
    parameter int SRC_MAX = rbd_pkg::SRC_MAX_DEF,
    parameter int DST_MAX = rbd_pkg::DST_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           src_valid,
    output logic                                src_ready,
    input  wire rbd_pkg::pixel_in_t             src_pixel,
    output logic                                dst_valid,
    input  wire logic                           dst_ready,
    output rbd_pkg::pixel_out_t                 dst_pixel,
    input  wire logic                           cfg_we,
    input  wire logic [rbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rbd_pkg::CFG_W-1:0]      cfg_data
);

    localparam int SRC_W = $clog2(SRC_MAX + 1);
    localparam int DST_W = $clog2(DST_MAX + 1);
    localparam int IDX_W = (DST_MAX > 1) ? $clog2(DST_MAX) : 1;
    localparam int N_W   = 2 * SRC_W;
    localparam int SUM_W = N_W + rbd_pkg::PIX_W;
    localparam int NCH   = rbd_pkg::NUM_CH;
    localparam int MEM_W = NCH * SUM_W;
    localparam int PW    = rbd_pkg::PIX_W;

    rbd_pkg::state_t state_reg, state_next;

    // configuration
    logic [rbd_pkg::SRC_CFG_W-1:0] src_width_reg, src_height_reg;
    logic [rbd_pkg::DST_CFG_W-1:0] dst_width_reg, dst_height_reg;
    logic                          cfg_hit;
    logic [SRC_W-1:0]              sw_clamp, sh_clamp;
    logic [DST_W-1:0]              dw_clamp, dh_clamp;

    // derived geometry
    logic [SRC_W-1:0] sw_reg, sh_reg, qw_reg, qh_reg;
    logic [DST_W-1:0] dw_reg, dh_reg, rw_reg, rh_reg;

    // position
    logic [SRC_W-1:0] src_col_reg, src_col_next, src_row_reg, src_row_next;
    logic [IDX_W-1:0] win_col_reg, win_col_next, win_row_reg, win_row_next;
    logic [SRC_W-1:0] col_start_reg, col_start_next, col_end_reg, col_end_next;
    logic [SRC_W-1:0] band_start_reg, band_start_next, band_end_reg, band_end_next;
    logic [DST_W-1:0] rcol_reg, rcol_next, rrow_reg, rrow_next;

    // handshake and control
    logic src_fire, mem_we, setup_start, div_start, out_load;
    logic setup_done, emit, first;

    // setup dividers
    logic             wdiv_done, hdiv_done;
    logic [SRC_W-1:0] wdiv_quot, hdiv_quot;
    logic [DST_W-1:0] wdiv_rem, hdiv_rem;

    // column store
    logic [MEM_W-1:0] col_sum_mem [DST_MAX];
    logic [MEM_W-1:0] mem_rdata_reg;
    logic [MEM_W-1:0] mem_wdata;

    // window result
    rbd_pkg::pixel_in_t px_reg;
    logic [PW-1:0]      px_ch [NCH];
    logic [SUM_W-1:0]   sum_reg [NCH];
    logic [N_W-1:0]     n_reg;
    logic [SRC_W-1:0]   cw, bh;
    logic [PW-1:0]      div_quot [NCH];
    logic [NCH-1:0]     div_done;
    logic [rbd_pkg::POS_W-1:0] res_col_reg, res_row_reg;
    logic               res_last_reg;

    logic               dst_valid_reg;
    rbd_pkg::pixel_out_t dst_pixel_reg;

    // ------------------------------------------------------------------
    // configuration registers and clamping
    // ------------------------------------------------------------------
    assign cfg_hit = cfg_we && (cfg_index == rbd_pkg::REG_SRC_WIDTH ||
                                cfg_index == rbd_pkg::REG_SRC_HEIGHT ||
                                cfg_index == rbd_pkg::REG_DST_WIDTH ||
                                cfg_index == rbd_pkg::REG_DST_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= rbd_pkg::SRC_CFG_W'(1);
            src_height_reg <= rbd_pkg::SRC_CFG_W'(1);
            dst_width_reg  <= rbd_pkg::DST_CFG_W'(1);
            dst_height_reg <= rbd_pkg::DST_CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbd_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[rbd_pkg::SRC_CFG_W-1:0];
                rbd_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[rbd_pkg::SRC_CFG_W-1:0];
                rbd_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data[rbd_pkg::DST_CFG_W-1:0];
                rbd_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data[rbd_pkg::DST_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        int sw_i, sh_i, wmax_i, hmax_i, dw_i, dh_i;
        sw_i = int'(src_width_reg);
        sh_i = int'(src_height_reg);
        if (sw_i < 1) sw_i = 1;
        if (sw_i > SRC_MAX) sw_i = SRC_MAX;
        if (sh_i < 1) sh_i = 1;
        if (sh_i > SRC_MAX) sh_i = SRC_MAX;
        wmax_i = (sw_i < DST_MAX) ? sw_i : DST_MAX;
        hmax_i = (sh_i < DST_MAX) ? sh_i : DST_MAX;
        dw_i = int'(dst_width_reg);
        dh_i = int'(dst_height_reg);
        if (dw_i < 1) dw_i = 1;
        if (dw_i > wmax_i) dw_i = wmax_i;
        if (dh_i < 1) dh_i = 1;
        if (dh_i > hmax_i) dh_i = hmax_i;
        sw_clamp = SRC_W'(sw_i);
        sh_clamp = SRC_W'(sh_i);
        dw_clamp = DST_W'(dw_i);
        dh_clamp = DST_W'(dh_i);
    end

    // window step sizes: sw/dw and sh/dh with remainders
    rbd_div #(.NUM_W(SRC_W), .DEN_W(DST_W), .Q_W(SRC_W)) u_wdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (setup_start),
        .num   (sw_clamp),
        .den   (dw_clamp),
        .done  (wdiv_done),
        .quot  (wdiv_quot),
        .rem   (wdiv_rem)
    );

    rbd_div #(.NUM_W(SRC_W), .DEN_W(DST_W), .Q_W(SRC_W)) u_hdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (setup_start),
        .num   (sh_clamp),
        .den   (dh_clamp),
        .done  (hdiv_done),
        .quot  (hdiv_quot),
        .rem   (hdiv_rem)
    );

    assign setup_done = wdiv_done && hdiv_done;

    always_ff @(posedge clk)
    begin
        if (setup_start)
        begin
            sw_reg <= sw_clamp;
            sh_reg <= sh_clamp;
            dw_reg <= dw_clamp;
            dh_reg <= dh_clamp;
        end
        if (state_reg == rbd_pkg::ST_SETUP_WAIT && setup_done)
        begin
            qw_reg <= wdiv_quot;
            qh_reg <= hdiv_quot;
            rw_reg <= wdiv_rem;
            rh_reg <= hdiv_rem;
        end
    end

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbd_pkg::ST_SETUP_GO:   state_next = rbd_pkg::ST_SETUP_WAIT;
            rbd_pkg::ST_SETUP_WAIT: if (setup_done) state_next = rbd_pkg::ST_IDLE;
            rbd_pkg::ST_IDLE:       if (src_fire) state_next = rbd_pkg::ST_UPDATE;
            rbd_pkg::ST_UPDATE:     state_next = emit ? rbd_pkg::ST_DIV_GO : rbd_pkg::ST_IDLE;
            rbd_pkg::ST_DIV_GO:     state_next = rbd_pkg::ST_DIV_WAIT;
            rbd_pkg::ST_DIV_WAIT:   if (&div_done) state_next = rbd_pkg::ST_OUT;
            rbd_pkg::ST_OUT:        if (out_load) state_next = rbd_pkg::ST_IDLE;
            default:                state_next = rbd_pkg::ST_SETUP_GO;
        endcase
        if (cfg_hit)
            state_next = rbd_pkg::ST_SETUP_GO;
    end

    always_comb
    begin
        src_ready   = (state_reg == rbd_pkg::ST_IDLE) && !cfg_hit;
        src_fire    = src_valid && src_ready;
        mem_we      = (state_reg == rbd_pkg::ST_UPDATE);
        setup_start = (state_reg == rbd_pkg::ST_SETUP_GO);
        div_start   = (state_reg == rbd_pkg::ST_DIV_GO);
        out_load    = (state_reg == rbd_pkg::ST_OUT) && (!dst_valid_reg || dst_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rbd_pkg::ST_SETUP_GO;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // position tracking
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [SRC_W-1:0] col_inc, row_inc;
        logic [DST_W:0]   rc_sum, rr_sum;
        logic             rc_carry, rr_carry;

        col_inc  = src_col_reg + 1'b1;
        row_inc  = src_row_reg + 1'b1;
        rc_sum   = {1'b0, rcol_reg} + {1'b0, rw_reg};
        rr_sum   = {1'b0, rrow_reg} + {1'b0, rh_reg};
        rc_carry = (rc_sum >= {1'b0, dw_reg});
        rr_carry = (rr_sum >= {1'b0, dh_reg});

        first = (src_row_reg == band_start_reg) && (src_col_reg == col_start_reg);
        emit  = (col_inc == col_end_reg) && (row_inc == band_end_reg);

        src_col_next    = src_col_reg;
        src_row_next    = src_row_reg;
        win_col_next    = win_col_reg;
        win_row_next    = win_row_reg;
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        band_start_next = band_start_reg;
        band_end_next   = band_end_reg;
        rcol_next       = rcol_reg;
        rrow_next       = rrow_reg;

        if (state_reg == rbd_pkg::ST_SETUP_WAIT && setup_done)
        begin
            src_col_next    = '0;
            src_row_next    = '0;
            win_col_next    = '0;
            win_row_next    = '0;
            col_start_next  = '0;
            col_end_next    = wdiv_quot;
            band_start_next = '0;
            band_end_next   = hdiv_quot;
            rcol_next       = wdiv_rem;
            rrow_next       = hdiv_rem;
        end
        else if (state_reg == rbd_pkg::ST_UPDATE)
        begin
            src_col_next = col_inc;
            // next window edge: previous edge + sw/dw, plus one on remainder carry
            if (col_inc >= col_end_reg)
            begin
                win_col_next   = win_col_reg + 1'b1;
                col_start_next = col_end_reg;
                col_end_next   = col_end_reg + qw_reg + SRC_W'(rc_carry);
                rcol_next      = rc_carry ? DST_W'(rc_sum - {1'b0, dw_reg})
                                          : DST_W'(rc_sum);
            end
            if (col_inc >= sw_reg)
            begin
                src_col_next   = '0;
                win_col_next   = '0;
                col_start_next = '0;
                col_end_next   = qw_reg;
                rcol_next      = rw_reg;
                src_row_next   = row_inc;
                if (row_inc >= band_end_reg)
                begin
                    win_row_next    = win_row_reg + 1'b1;
                    band_start_next = band_end_reg;
                    band_end_next   = band_end_reg + qh_reg + SRC_W'(rr_carry);
                    rrow_next       = rr_carry ? DST_W'(rr_sum - {1'b0, dh_reg})
                                               : DST_W'(rr_sum);
                end
                if (row_inc >= sh_reg)
                begin
                    src_row_next    = '0;
                    win_row_next    = '0;
                    band_start_next = '0;
                    band_end_next   = qh_reg;
                    rrow_next       = rh_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            win_col_reg    <= '0;
            win_row_reg    <= '0;
            col_start_reg  <= '0;
            col_end_reg    <= SRC_W'(1);
            band_start_reg <= '0;
            band_end_reg   <= SRC_W'(1);
            rcol_reg       <= '0;
            rrow_reg       <= '0;
        end
        else
        begin
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            win_col_reg    <= win_col_next;
            win_row_reg    <= win_row_next;
            col_start_reg  <= col_start_next;
            col_end_reg    <= col_end_next;
            band_start_reg <= band_start_next;
            band_end_reg   <= band_end_next;
            rcol_reg       <= rcol_next;
            rrow_reg       <= rrow_next;
        end
    end

    // ------------------------------------------------------------------
    // column store: read on transfer, write back in the next cycle
    // ------------------------------------------------------------------
    assign px_ch[0] = px_reg.in_red;
    assign px_ch[1] = px_reg.in_green;
    assign px_ch[2] = px_reg.in_blue;
    assign px_ch[3] = px_reg.in_alpha;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            mem_wdata[c*SUM_W +: SUM_W] = first ? SUM_W'(px_ch[c])
                : mem_rdata_reg[c*SUM_W +: SUM_W] + SUM_W'(px_ch[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_fire)
            mem_rdata_reg <= col_sum_mem[win_col_reg];
        if (mem_we)
            col_sum_mem[win_col_reg] <= mem_wdata;
    end

    assign cw = col_end_reg - col_start_reg;
    assign bh = band_end_reg - band_start_reg;

    always_ff @(posedge clk)
    begin
        if (src_fire)
            px_reg <= src_pixel;
        if (state_reg == rbd_pkg::ST_UPDATE)
        begin
            for (int c = 0; c < NCH; c++)
                sum_reg[c] <= mem_wdata[c*SUM_W +: SUM_W];
            n_reg        <= N_W'(cw) * N_W'(bh);
            res_col_reg  <= rbd_pkg::POS_W'(win_col_reg);
            res_row_reg  <= rbd_pkg::POS_W'(win_row_reg);
            res_last_reg <= (DST_W'(win_col_reg) + 1'b1 == dw_reg) &&
                            (DST_W'(win_row_reg) + 1'b1 == dh_reg);
        end
    end

    // ------------------------------------------------------------------
    // averaging: one divider per channel
    // ------------------------------------------------------------------
    for (genvar c = 0; c < NCH; c++)
    begin : g_avg
        rbd_div #(.NUM_W(SUM_W), .DEN_W(N_W), .Q_W(PW)) u_avg (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (sum_reg[c]),
            .den   (n_reg),
            .done  (div_done[c]),
            .quot  (div_quot[c]),
            .rem   ()
        );
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dst_valid_reg <= 1'b0;
        else if (out_load)
            dst_valid_reg <= 1'b1;
        else if (dst_ready)
            dst_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dst_pixel_reg.out_red    <= div_quot[0];
            dst_pixel_reg.out_green  <= div_quot[1];
            dst_pixel_reg.out_blue   <= div_quot[2];
            dst_pixel_reg.out_alpha  <= div_quot[3];
            dst_pixel_reg.out_col    <= res_col_reg;
            dst_pixel_reg.out_row    <= res_row_reg;
            dst_pixel_reg.frame_last <= res_last_reg;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_pixel = dst_pixel_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_wb_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> $past(src_valid && src_ready))
        else $error("column write-back without a preceding read");

    a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbd_pkg::ST_DIV_GO) |-> (n_reg != '0))
        else $error("averaging started on an empty window");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rbd_pkg::ST_IDLE) |->
            (DST_W'(win_col_reg) < dw_reg && src_col_reg < sw_reg))
        else $error("position outside the image while idle");

endmodule
`default_nettype wire
